FILE: hdl/tsb_pkg.sv
// Package for the slotted bucket with tombstone bitmaps.
// Holds the operation codes, fixed port widths and default parameter values.
// No dependencies.
package tsb_pkg;

  localparam int SLOTS_DEF      = 32;
  localparam int VALUE_BITS_DEF = 64;
  localparam int RESULT_LIMIT   = 32;

  localparam int ITEM_W      = 64;
  localparam int SLOT_IN_W   = 5;
  localparam int SLOT_OUT_W  = 5;
  localparam int COUNT_OUT_W = 6;
  localparam int OP_W        = 2;

  localparam logic [OP_W-1:0] OP_INSERT    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE    = 2'd1;
  localparam logic [OP_W-1:0] OP_SCAN      = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_AT = 2'd3;

endpackage

FILE: hdl/tombstone_slot_bucket.sv
// Slotted bucket with live and used bitmaps; values held in tsb_ram.
// Insert and remove-at-slot give their result in the cycle after the transaction.
// Remove and scan read one candidate slot per cycle from the value RAM, walking
// the live slots below the first never-used slot; a stalled output holds the
// walk. Uses tsb_pkg.
// Reset clears the bitmaps and count at once; the value RAM is not cleared.
module tombstone_slot_bucket import tsb_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        operation,
  input  logic [ITEM_W-1:0]      item_value,
  input  logic [SLOT_IN_W-1:0]   slot_index,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   ok,
  output logic [ITEM_W-1:0]      out_value,
  output logic [SLOT_OUT_W-1:0]  out_slot,
  output logic                   last,
  output logic [COUNT_OUT_W-1:0] live_count,
  output logic                   is_full,
  output logic                   is_empty
);

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int IDX_W   = ((SLOT_W > SLOT_IN_W) ? SLOT_W : SLOT_IN_W) + 1;
  localparam int EMIT_W  = $clog2(RESULT_LIMIT);
  localparam logic [SLOTS-1:0] ALL_SLOTS = '1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                  state, state_next;
  logic [OP_W-1:0]       op_reg, op_reg_next;
  logic [VALUE_BITS-1:0] val_reg, val_reg_next;
  logic [SLOTS-1:0]      remaining, remaining_next;
  logic                  rd_pend, rd_pend_next;
  logic [SLOT_W-1:0]     rd_slot, rd_slot_next;
  logic [EMIT_W-1:0]     nemit, nemit_next;
  logic [SLOTS-1:0]      live, live_next;
  logic [SLOTS-1:0]      used, used_next;
  logic [CNT_W-1:0]      cnt, cnt_next;

  logic                  out_valid_next;
  logic                  emit;
  logic                  emit_ok;
  logic [ITEM_W-1:0]     emit_value;
  logic [SLOT_OUT_W-1:0] emit_slot;
  logic                  emit_last;

  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [SLOT_W-1:0]     ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic [SLOTS-1:0]      region;
  logic [SLOTS-1:0]      cand;
  logic [SLOT_W-1:0]     free_slot;
  logic                  free_found;
  logic [SLOT_W-1:0]     next_slot;
  logic [IDX_W-1:0]      idx_ext;
  logic                  idx_live;
  logic                  out_free;
  logic                  consume;
  logic                  done;
  logic                  accept;

  tsb_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (SLOTS)
  ) u_values (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Slots below the first never-used slot are the trailing ones of the used map.
  assign region  = used & ~(used + SLOTS'(1));
  assign cand    = live & region;
  assign idx_ext = IDX_W'(slot_index);
  assign idx_live = (idx_ext < IDX_W'(SLOTS)) && live[idx_ext[SLOT_W-1:0]];

  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    next_slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_slot  = SLOT_W'(i);
        free_found = 1'b1;
      end
      if (remaining[i]) begin
        next_slot = SLOT_W'(i);
      end
    end
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign consume  = (state == ST_WALK) && rd_pend && out_free;

  always_comb begin
    state_next     = state;
    op_reg_next    = op_reg;
    val_reg_next   = val_reg;
    remaining_next = remaining;
    rd_pend_next   = rd_pend;
    rd_slot_next   = rd_slot;
    nemit_next     = nemit;
    live_next      = live;
    used_next      = used;
    cnt_next       = cnt;
    emit           = 1'b0;
    emit_ok        = 1'b0;
    emit_value     = '0;
    emit_slot      = '0;
    emit_last      = 1'b1;
    ram_we         = 1'b0;
    ram_waddr      = free_slot;
    ram_wdata      = item_value[VALUE_BITS-1:0];
    ram_re         = 1'b0;
    ram_raddr      = next_slot;
    done           = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (operation)
            OP_INSERT: begin
              emit = 1'b1;
              if (free_found) begin
                ram_we    = 1'b1;
                live_next = live | (SLOTS'(1) << free_slot);
                used_next = used | (SLOTS'(1) << free_slot);
                cnt_next  = cnt + CNT_W'(1);
                emit_ok   = 1'b1;
                emit_slot = SLOT_OUT_W'(free_slot);
              end
            end
            OP_REMOVE_AT: begin
              emit      = 1'b1;
              emit_slot = slot_index;
              if (idx_live) begin
                live_next = live & ~(SLOTS'(1) << idx_ext[SLOT_W-1:0]);
                cnt_next  = cnt - CNT_W'(1);
                emit_ok   = 1'b1;
              end
            end
            default: begin
              if (cand == '0) begin
                emit = 1'b1;
              end else begin
                state_next     = ST_WALK;
                op_reg_next    = operation;
                val_reg_next   = item_value[VALUE_BITS-1:0];
                remaining_next = cand;
                rd_pend_next   = 1'b0;
                nemit_next     = '0;
              end
            end
          endcase
        end
      end
      ST_WALK: begin
        if (consume) begin
          if (op_reg == OP_SCAN) begin
            emit       = 1'b1;
            emit_ok    = 1'b1;
            emit_value = ITEM_W'(ram_rdata);
            emit_slot  = SLOT_OUT_W'(rd_slot);
            emit_last  = (remaining == '0) || (nemit == EMIT_W'(RESULT_LIMIT - 1));
            nemit_next = nemit + EMIT_W'(1);
            done       = emit_last;
          end else if (ram_rdata == val_reg) begin
            emit      = 1'b1;
            emit_ok   = 1'b1;
            emit_slot = SLOT_OUT_W'(rd_slot);
            live_next = live & ~(SLOTS'(1) << rd_slot);
            cnt_next  = cnt - CNT_W'(1);
            done      = 1'b1;
          end else if (remaining == '0) begin
            emit = 1'b1;
            done = 1'b1;
          end
        end
        if (done) begin
          state_next   = ST_IDLE;
          rd_pend_next = 1'b0;
        end else if ((remaining != '0) && (!rd_pend || consume)) begin
          ram_re         = 1'b1;
          remaining_next = remaining & ~(SLOTS'(1) << next_slot);
          rd_pend_next   = 1'b1;
          rd_slot_next   = next_slot;
        end else if (consume) begin
          rd_pend_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_pend   <= 1'b0;
      live      <= '0;
      used      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_pend   <= rd_pend_next;
      live      <= live_next;
      used      <= used_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_reg    <= op_reg_next;
    val_reg   <= val_reg_next;
    remaining <= remaining_next;
    rd_slot   <= rd_slot_next;
    nemit     <= nemit_next;
    if (emit) begin
      ok         <= emit_ok;
      out_value  <= emit_value;
      out_slot   <= emit_slot;
      last       <= emit_last;
      live_count <= COUNT_OUT_W'(cnt_next);
      is_full    <= (live_next == ALL_SLOTS);
      is_empty   <= (live_next == '0);
    end
  end

  a_count_matches_live: assert property (@(posedge clk) disable iff (rst)
    cnt == CNT_W'($countones(live)))
    else $error("live count differs from the live bitmap");

  a_live_within_used: assert property (@(posedge clk) disable iff (rst)
    (live & ~used) == '0)
    else $error("a live slot is not marked as used");

  a_walk_only_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> ((remaining & ~live) == '0))
    else $error("walk holds a slot that is no longer live");

  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !in_ready)
    else $error("new transaction taken during a walk");

endmodule

FILE: hdl/tsb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the value store of the slotted bucket. No dependencies.
module tsb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
